// File: design/iebm_pkg.sv
// iebm_pkg: types and constants shared by the eeprom byte master modules
// no dependencies

package iebm_pkg;

   typedef enum logic [1:0] {
      REQ_NONE  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2
   } req_kind_type;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_START    = 5'd1,
      PH_TX_DEVW  = 5'd2,
      PH_ACK_DEVW = 5'd3,
      PH_TX_WORD  = 5'd4,
      PH_ACK_WORD = 5'd5,
      PH_TX_DATA  = 5'd6,
      PH_ACK_DATA = 5'd7,
      PH_RSTART   = 5'd8,
      PH_TX_DEVR  = 5'd9,
      PH_ACK_DEVR = 5'd10,
      PH_RX       = 5'd11,
      PH_NACK     = 5'd12,
      PH_STOP     = 5'd13,
      PH_RECOVERY = 5'd14
   } phase_type;

   localparam logic       CSR_DEVICE_ADDRESS   = 1'b0;
   localparam logic       CSR_WRITE_RECOVERY   = 1'b1;
   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
   localparam logic [15:0] WRITE_RECOVERY_RESET = 16'd2500;
   localparam logic       RW_WRITE             = 1'b0;
   localparam logic       RW_READ              = 1'b1;
   localparam logic [3:0] LAST_BIT_TICK        = 4'd15;

   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   word_address;
      logic [7:0]   write_data;
      logic         sda_in;
   } tick_type;

   typedef struct packed {
      logic     valid;
      tick_type tick;
   } queue_head_type;

   typedef struct packed {
      logic       scl;
      logic       sda_release;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
      logic       ack_missing;
   } result_type;

endpackage

// File: design/iebm_front.sv
// iebm_front: accepts bus tick words, decodes the request and holds them in a
// two-entry queue for the sequencer; uses iebm_pkg

module iebm_front import iebm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_operation,
   input  logic [7:0]   req_word_address,
   input  logic [7:0]   req_write_data,
   input  logic         req_sda_in,
   input  logic         pop,
   output queue_head_type head
);

   logic [1:0] count_ff, count_in;
   tick_type   entry0_ff, entry0_in;
   tick_type   entry1_ff, entry1_in;
   tick_type   incoming;
   logic       push;

   always_comb begin
      unique case (req_operation)
         REQ_WRITE: incoming.kind = REQ_WRITE;
         REQ_READ:  incoming.kind = REQ_READ;
         default:   incoming.kind = REQ_NONE;
      endcase
      incoming.word_address = req_word_address;
      incoming.write_data   = req_write_data;
      incoming.sda_in       = req_sda_in;
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign head.valid = (count_ff != 2'd0);
   assign head.tick  = entry0_ff;

   always_comb begin
      count_in  = count_ff;
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      if (pop && (count_ff != 2'd0)) begin
         entry0_in = entry1_ff;
         if (push) begin
            if (count_ff == 2'd1) begin
               entry0_in = incoming;
            end else begin
               entry1_in = incoming;
            end
         end else begin
            count_in = count_ff - 2'd1;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            entry0_in = incoming;
         end else begin
            entry1_in = incoming;
         end
         count_in = count_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

endmodule

// File: design/iebm_back.sv
// iebm_back: bus sequencer that does one queued tick per cycle unless rsp
// stalls; registers its result word; holds the configuration; uses iebm_pkg

module iebm_back import iebm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  logic           csr_index,
   input  logic [15:0]    csr_write_data,
   input  queue_head_type head,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output result_type     result
);

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  held_address_ff, held_address_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic        is_read_ff, is_read_in;
   logic [15:0] timer_ff, timer_in;
   logic        ack_error_ff, ack_error_in;
   logic [6:0]  device_address_ff;
   logic [15:0] write_recovery_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  result_ff, result_in;
   logic        half;
   logic        advance;

   assign advance   = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop       = advance;
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;
   assign half      = bit_count_ff[0];

   always_comb begin
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      shift_in        = shift_ff;
      held_address_in = held_address_ff;
      held_data_in    = held_data_ff;
      is_read_in      = is_read_ff;
      timer_in        = timer_ff;
      ack_error_in    = ack_error_ff;
      result_in.scl         = 1'b1;
      result_in.sda_release = 1'b1;
      result_in.busy_res    = 1'b1;
      result_in.read_data   = 8'd0;
      result_in.read_valid  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            result_in.busy_res = 1'b0;
            if (head.tick.kind != REQ_NONE) begin
               held_address_in       = head.tick.word_address;
               held_data_in          = head.tick.write_data;
               is_read_in            = (head.tick.kind == REQ_READ);
               ack_error_in          = 1'b0;
               result_in.busy_res    = 1'b1;
               result_in.sda_release = 1'b0;
               phase_in              = PH_START;
               bit_count_in          = 4'd0;
               shift_in              = 8'd0;
            end
         end
         PH_START: begin
            result_in.scl         = 1'b0;
            result_in.sda_release = 1'b0;
            phase_in              = PH_TX_DEVW;
            bit_count_in          = 4'd0;
            shift_in              = {device_address_ff, RW_WRITE};
         end
         PH_TX_DEVW, PH_TX_WORD, PH_TX_DATA, PH_TX_DEVR: begin
            result_in.scl         = half;
            result_in.sda_release = shift_ff[7];
            if (half) begin
               shift_in = {shift_ff[6:0], 1'b0};
            end
            if (bit_count_ff == LAST_BIT_TICK) begin
               bit_count_in = 4'd0;
               unique case (phase_ff)
                  PH_TX_DEVW: phase_in = PH_ACK_DEVW;
                  PH_TX_WORD: phase_in = PH_ACK_WORD;
                  PH_TX_DATA: phase_in = PH_ACK_DATA;
                  default:    phase_in = PH_ACK_DEVR;
               endcase
            end else begin
               bit_count_in = bit_count_ff + 4'd1;
            end
         end
         PH_ACK_DEVW, PH_ACK_WORD, PH_ACK_DATA, PH_ACK_DEVR: begin
            result_in.scl = half;
            if (!half) begin
               bit_count_in = 4'd1;
            end else begin
               if (head.tick.sda_in) begin
                  ack_error_in = 1'b1;
               end
               bit_count_in = 4'd0;
               unique case (phase_ff)
                  PH_ACK_DEVW: begin
                     phase_in = PH_TX_WORD;
                     shift_in = held_address_ff;
                  end
                  PH_ACK_WORD: begin
                     if (is_read_ff) begin
                        phase_in = PH_RSTART;
                        shift_in = 8'd0;
                     end else begin
                        phase_in = PH_TX_DATA;
                        shift_in = held_data_ff;
                     end
                  end
                  PH_ACK_DATA: begin
                     phase_in = PH_STOP;
                     shift_in = 8'd0;
                  end
                  default: begin
                     phase_in = PH_RX;
                     shift_in = 8'd0;
                  end
               endcase
            end
         end
         PH_RSTART: begin
            result_in.scl         = (bit_count_ff == 4'd1) || (bit_count_ff == 4'd2);
            result_in.sda_release = (bit_count_ff <= 4'd1);
            if (bit_count_ff >= 4'd3) begin
               phase_in     = PH_TX_DEVR;
               bit_count_in = 4'd0;
               shift_in     = {device_address_ff, RW_READ};
            end else begin
               bit_count_in = bit_count_ff + 4'd1;
            end
         end
         PH_RX: begin
            result_in.scl = half;
            if (half) begin
               shift_in = {shift_ff[6:0], head.tick.sda_in};
            end
            if (bit_count_ff == LAST_BIT_TICK) begin
               phase_in     = PH_NACK;
               bit_count_in = 4'd0;
            end else begin
               bit_count_in = bit_count_ff + 4'd1;
            end
         end
         PH_NACK: begin
            result_in.scl = half;
            if (half) begin
               phase_in     = PH_STOP;
               bit_count_in = 4'd0;
            end else begin
               bit_count_in = 4'd1;
            end
         end
         PH_STOP: begin
            result_in.scl         = (bit_count_ff >= 4'd1);
            result_in.sda_release = (bit_count_ff >= 4'd2);
            if (bit_count_ff < 4'd2) begin
               bit_count_in = bit_count_ff + 4'd1;
            end else begin
               bit_count_in = 4'd0;
               if (is_read_ff) begin
                  result_in.read_valid = 1'b1;
                  result_in.read_data  = shift_ff;
                  phase_in             = PH_IDLE;
               end else begin
                  timer_in = write_recovery_ff;
                  phase_in = (write_recovery_ff == 16'd0) ? PH_IDLE : PH_RECOVERY;
               end
            end
         end
         PH_RECOVERY: begin
            if (timer_ff != 16'd0) begin
               timer_in = timer_ff - 16'd1;
            end
            if ((timer_ff == 16'd0) || (timer_ff == 16'd1)) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            result_in.busy_res = 1'b0;
            phase_in           = PH_IDLE;
            bit_count_in       = 4'd0;
            shift_in           = 8'd0;
         end
      endcase
      result_in.ack_missing = ack_error_in;
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         bit_count_ff      <= 4'd0;
         ack_error_ff      <= 1'b0;
         is_read_ff        <= 1'b0;
         timer_ff          <= 16'd0;
         shift_ff          <= 8'd0;
         rsp_valid_ff      <= 1'b0;
         device_address_ff <= DEVICE_ADDRESS_RESET;
         write_recovery_ff <= WRITE_RECOVERY_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            ack_error_ff <= ack_error_in;
            is_read_ff   <= is_read_in;
            timer_ff     <= timer_in;
            shift_ff     <= shift_in;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DEVICE_ADDRESS: device_address_ff <= csr_write_data[6:0];
               CSR_WRITE_RECOVERY: write_recovery_ff <= csr_write_data;
            endcase
         end
      end
      if (advance) begin
         held_address_ff <= held_address_in;
         held_data_ff    <= held_data_in;
         result_ff       <= result_in;
      end
   end

endmodule

// File: design/i2c_eeprom_byte_master.sv
// i2c_eeprom_byte_master: top level of the serial eeprom byte master
// depends on iebm_pkg, iebm_front and iebm_back

// Each req word is one bus tick and yields exactly one rsp word with the scl
// and sda levels, busy, read data and the missing-ack flag. One tick is taken
// every clock cycle while neither req_stall nor rsp_stall holds it back; a word
// passes through the two-entry input queue and then the sequencer's registered
// result word before it reaches the rsp ports. A request code is looked at only
// on a tick that finds the sequencer idle. The user must write configuration via
// the csr port only while no transaction is running; the block does not check it.

module i2c_eeprom_byte_master import iebm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [15:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_word_address,
   input  logic [7:0]  req_write_data,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_scl,
   output logic        rsp_sda_release,
   output logic        rsp_busy_res,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_read_valid,
   output logic        rsp_ack_missing
);

   queue_head_type head;
   logic           pop;
   result_type     result;

   iebm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_word_address (req_word_address),
      .req_write_data   (req_write_data),
      .req_sda_in       (req_sda_in),
      .pop              (pop),
      .head             (head)
   );

   iebm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .result           (result)
   );

   assign rsp_scl         = result.scl;
   assign rsp_sda_release = result.sda_release;
   assign rsp_busy_res    = result.busy_res;
   assign rsp_read_data   = result.read_data;
   assign rsp_read_valid  = result.read_valid;
   assign rsp_ack_missing = result.ack_missing;

endmodule

// File: design/iebm_checker.sv
// iebm_checker: port-level assertions for i2c_eeprom_byte_master, with bind
// depends only on the top level's ports

module iebm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_scl,
   input logic       rsp_sda_release,
   input logic       rsp_busy_res,
   input logic [7:0] rsp_read_data,
   input logic       rsp_read_valid,
   input logic       rsp_ack_missing
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scl) && $stable(rsp_sda_release)
         && $stable(rsp_busy_res) && $stable(rsp_read_data) && $stable(rsp_read_valid)
         && $stable(rsp_ack_missing))
      else $error("rsp word changed while stalled");

   a_read_at_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> rsp_busy_res && rsp_scl && rsp_sda_release)
      else $error("read completion outside the stop edge");

   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_data == 8'd0)
      else $error("read data without read valid");

   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_scl && rsp_sda_release)
      else $error("bus lines held while idle");

endmodule

bind i2c_eeprom_byte_master iebm_checker u_iebm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_scl         (rsp_scl),
   .rsp_sda_release (rsp_sda_release),
   .rsp_busy_res    (rsp_busy_res),
   .rsp_read_data   (rsp_read_data),
   .rsp_read_valid  (rsp_read_valid),
   .rsp_ack_missing (rsp_ack_missing)
);
